@@ rtl/kesgc_pkg.sv @@
// kesgc_pkg: shared types, widths, register codes and fixed-point helpers
// for the kinematic euler step unit; depends on nothing
package kesgc_pkg;

  // field widths fixed by the interface
  localparam int WORD_W    = 32;
  localparam int DT_W      = 17;
  localparam int DAMP_W    = 31;
  localparam int FLAGS_W   = 5;
  localparam int CFG_IDX_W = 2;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  localparam int ONE       = 1 << FRAC_BITS;

  // intermediate widths, all derived from the format
  localparam int SUM_W    = WORD_W + 1;
  localparam int P1_W     = SUM_W + DT_W + 1;
  localparam int R1_W     = P1_W - FRAC_BITS;
  localparam int V_W      = ((R1_W > WORD_W) ? R1_W : WORD_W) + 1;
  localparam int FACTOR_W = FRAC_BITS + 1;
  localparam int P2_W     = V_W + FACTOR_W + 1;
  localparam int DP_W     = DAMP_W + DT_W;
  localparam int DR_W     = DP_W - FRAC_BITS + 1;
  localparam int P3_W     = WORD_W + DT_W + 1;
  localparam int R3_W     = P3_W - FRAC_BITS;
  localparam int PS_W     = ((R3_W > WORD_W) ? R3_W : WORD_W) + 1;

  // saturation bounds
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // flag bit positions
  localparam int FLAG_KINEMATIC      = 0;
  localparam int FLAG_ACTIVE         = 1;
  localparam int FLAG_IGNORE_GRAVITY = 2;
  localparam int FLAG_IGNORE_TERRAIN = 3;
  localparam int FLAG_FLOOR_PRESENT  = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY_X = 2'd0,
    REG_GRAVITY_Y = 2'd1,
    REG_GRAVITY_Z = 2'd2,
    REG_TIME_STEP = 2'd3
  } reg_idx_t;

  // reset values
  localparam logic [WORD_W-1:0] GRAVITY_X_RST = 32'd0;
  localparam logic [WORD_W-1:0] GRAVITY_Y_RST = 32'hFFF6_30A4;  // -642908
  localparam logic [WORD_W-1:0] GRAVITY_Z_RST = 32'd0;
  localparam logic [DT_W-1:0]   TIME_STEP_RST = 17'd1092;

  typedef struct packed {
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] vel_z;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic [DAMP_W-1:0]        damping_rate;
    logic [FLAGS_W-1:0]       body_flags;
    logic signed [WORD_W-1:0] floor_height;
  } body_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_vel_x;
    logic signed [WORD_W-1:0] new_vel_y;
    logic signed [WORD_W-1:0] new_vel_z;
    logic signed [WORD_W-1:0] new_pos_x;
    logic signed [WORD_W-1:0] new_pos_y;
    logic signed [WORD_W-1:0] new_pos_z;
    logic                     was_updated;
    logic                     ground_contact;
  } result_t;

  // live configuration
  typedef struct packed {
    logic [WORD_W-1:0] gravity_x;
    logic [WORD_W-1:0] gravity_y;
    logic [WORD_W-1:0] gravity_z;
    logic [DT_W-1:0]   time_step;
  } cfg_t;

  // side data that rides along the pipeline
  typedef struct packed {
    logic [2:0][WORD_W-1:0] vel;
    logic [2:0][WORD_W-1:0] pos;
    logic [WORD_W-1:0]      floor_h;
    logic                   clamp_en;
    logic                   upd;
  } carry_t;

  // beat from the velocity pipe to the position pipe
  typedef struct packed {
    logic [2:0][WORD_W-1:0] vel;
    carry_t                 side;
  } mid_t;

  // product shifted down by the fraction bits, round half up
  function automatic logic signed [63:0] round_shr(input logic signed [63:0] p);
    return (p + 64'(HALF)) >>> FRAC_BITS;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > WORD_MAX) r = WORD_MAX[WORD_W-1:0];
    else if (x < WORD_MIN) r = WORD_MIN[WORD_W-1:0];
    else r = x[WORD_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/kesgc_cfg_regs.sv @@
// kesgc_cfg_regs: gravity and time step registers behind the write port
// depends on kesgc_pkg
module kesgc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kesgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kesgc_pkg::WORD_W-1:0] cfg_data,
  output kesgc_pkg::cfg_t              cfg
);
  import kesgc_pkg::*;

  cfg_t regs;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gravity_x <= GRAVITY_X_RST;
      regs.gravity_y <= GRAVITY_Y_RST;
      regs.gravity_z <= GRAVITY_Z_RST;
      regs.time_step <= TIME_STEP_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRAVITY_X: regs.gravity_x <= cfg_data;
        REG_GRAVITY_Y: regs.gravity_y <= cfg_data;
        REG_GRAVITY_Z: regs.gravity_z <= cfg_data;
        REG_TIME_STEP: regs.time_step <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ rtl/kesgc_vel_pipe.sv @@
// kesgc_vel_pipe: four-stage velocity path: acceleration times dt, velocity
// sum and damping factor, damping product, rounding and saturation; uses kesgc_pkg
module kesgc_vel_pipe (
  input  logic               clk,
  input  logic               rst,
  input  kesgc_pkg::cfg_t    cfg,
  input  logic               body_valid,
  output logic               body_ready,
  input  kesgc_pkg::body_t   body_data,
  output logic               mid_valid,
  input  logic               mid_ready,
  output kesgc_pkg::mid_t    mid_data
);
  import kesgc_pkg::*;

  // stage valid bits and advance enables
  logic s1_vld, s2_vld, s3_vld, s4_vld;
  logic s1_adv, s2_adv, s3_adv, s4_adv;

  assign s4_adv = !s4_vld || mid_ready;
  assign s3_adv = !s3_vld || s4_adv;
  assign s2_adv = !s2_vld || s3_adv;
  assign s1_adv = !s1_vld || s2_adv;
  assign body_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      if (s1_adv) s1_vld <= body_valid;
      if (s2_adv) s2_vld <= s1_vld;
      if (s3_adv) s3_vld <= s2_vld;
      if (s4_adv) s4_vld <= s3_vld;
    end
  end

  // stage 1: (gravity + accel) * dt, damping * dt
  logic signed [WORD_W-1:0] grav [3];
  logic signed [WORD_W-1:0] acc [3];
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [DT_W:0]     dt_s;
  logic signed [P1_W-1:0]   s1_p1_next [3];
  logic [DP_W-1:0]          s1_dp_next;
  carry_t                   s1_side_next;

  always_comb begin
    dt_s    = $signed({1'b0, cfg.time_step});
    grav[0] = $signed(cfg.gravity_x);
    grav[1] = $signed(cfg.gravity_y);
    grav[2] = $signed(cfg.gravity_z);
    acc[0]  = body_data.accel_x;
    acc[1]  = body_data.accel_y;
    acc[2]  = body_data.accel_z;
    for (int i = 0; i < 3; i++) begin
      if (body_data.body_flags[FLAG_IGNORE_GRAVITY]) grav[i] = '0;
      sum[i] = SUM_W'(grav[i]) + SUM_W'(acc[i]);
      s1_p1_next[i] = P1_W'(sum[i]) * P1_W'(dt_s);
    end
    s1_dp_next = DP_W'(body_data.damping_rate) * DP_W'(cfg.time_step);
    s1_side_next.vel[0]  = body_data.vel_x;
    s1_side_next.vel[1]  = body_data.vel_y;
    s1_side_next.vel[2]  = body_data.vel_z;
    s1_side_next.pos[0]  = body_data.pos_x;
    s1_side_next.pos[1]  = body_data.pos_y;
    s1_side_next.pos[2]  = body_data.pos_z;
    s1_side_next.floor_h = body_data.floor_height;
    s1_side_next.clamp_en = !body_data.body_flags[FLAG_IGNORE_TERRAIN] &&
                            body_data.body_flags[FLAG_FLOOR_PRESENT];
    s1_side_next.upd = body_data.body_flags[FLAG_KINEMATIC] &&
                       body_data.body_flags[FLAG_ACTIVE] &&
                       (cfg.time_step != '0);
  end

  logic signed [P1_W-1:0] s1_p1 [3];
  logic [DP_W-1:0]        s1_dp;
  carry_t                 s1_side;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_p1   <= s1_p1_next;
      s1_dp   <= s1_dp_next;
      s1_side <= s1_side_next;
    end
  end

  // stage 2: integrated velocity and damping factor
  logic signed [V_W-1:0]  s2_v_next [3];
  logic [DR_W-1:0]        dr;
  logic [FACTOR_W-1:0]    s2_factor_next;
  logic signed [63:0]     dr_wide;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_v_next[i] = V_W'($signed(s1_side.vel[i])) +
                     V_W'(round_shr(64'(s1_p1[i])));
    end
    dr_wide = round_shr(64'(s1_dp));
    dr = dr_wide[DR_W-1:0];
    if (dr >= DR_W'(ONE)) s2_factor_next = '0;
    else s2_factor_next = FACTOR_W'(DR_W'(ONE) - dr);
  end

  logic signed [V_W-1:0] s2_v [3];
  logic [FACTOR_W-1:0]   s2_factor;
  carry_t                s2_side;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_v      <= s2_v_next;
      s2_factor <= s2_factor_next;
      s2_side   <= s1_side;
    end
  end

  // stage 3: damping product
  logic signed [P2_W-1:0] s3_p2_next [3];
  logic signed [FACTOR_W:0] factor_s;

  always_comb begin
    factor_s = $signed({1'b0, s2_factor});
    for (int i = 0; i < 3; i++) begin
      s3_p2_next[i] = P2_W'(s2_v[i]) * P2_W'(factor_s);
    end
  end

  logic signed [P2_W-1:0] s3_p2 [3];
  carry_t                 s3_side;

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_p2   <= s3_p2_next;
      s3_side <= s2_side;
    end
  end

  // stage 4: round, saturate, or pass the old velocity through
  mid_t s4_next;

  always_comb begin
    s4_next.side = s3_side;
    for (int i = 0; i < 3; i++) begin
      if (s3_side.upd) s4_next.vel[i] = sat32(round_shr(64'(s3_p2[i])));
      else s4_next.vel[i] = s3_side.vel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_adv) mid_data <= s4_next;
  end

  assign mid_valid = s4_vld;

endmodule

@@ rtl/kesgc_pos_pipe.sv @@
// kesgc_pos_pipe: two-stage position path: velocity times dt, then position
// sum, saturation, floor clamp and the output register; uses kesgc_pkg
module kesgc_pos_pipe (
  input  logic               clk,
  input  logic               rst,
  input  kesgc_pkg::cfg_t    cfg,
  input  logic               mid_valid,
  output logic               mid_ready,
  input  kesgc_pkg::mid_t    mid_data,
  output logic               result_valid,
  input  logic               result_ready,
  output kesgc_pkg::result_t result_data
);
  import kesgc_pkg::*;

  logic s5_vld, s6_vld;
  logic s5_adv, s6_adv;

  assign s6_adv = !s6_vld || result_ready;
  assign s5_adv = !s5_vld || s6_adv;
  assign mid_ready = s5_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else begin
      if (s5_adv) s5_vld <= mid_valid;
      if (s6_adv) s6_vld <= s5_vld;
    end
  end

  // stage 5: new velocity times dt
  logic signed [P3_W-1:0] s5_p3_next [3];
  logic signed [DT_W:0]   dt_s;

  always_comb begin
    dt_s = $signed({1'b0, cfg.time_step});
    for (int i = 0; i < 3; i++) begin
      s5_p3_next[i] = P3_W'($signed(mid_data.vel[i])) * P3_W'(dt_s);
    end
  end

  logic signed [P3_W-1:0] s5_p3 [3];
  mid_t                   s5_mid;

  always_ff @(posedge clk) begin
    if (s5_adv) begin
      s5_p3  <= s5_p3_next;
      s5_mid <= mid_data;
    end
  end

  // stage 6: position update, floor clamp
  logic signed [PS_W-1:0]   ps [3];
  logic signed [WORD_W-1:0] np [3];
  logic signed [WORD_W-1:0] nv [3];
  logic                     contact;
  result_t                  s6_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps[i] = PS_W'($signed(s5_mid.side.pos[i])) + PS_W'(round_shr(64'(s5_p3[i])));
      nv[i] = $signed(s5_mid.vel[i]);
      if (s5_mid.side.upd) np[i] = sat32(64'(ps[i]));
      else np[i] = $signed(s5_mid.side.pos[i]);
    end
    contact = s5_mid.side.upd && s5_mid.side.clamp_en &&
              (np[1] < $signed(s5_mid.side.floor_h)) && nv[1][WORD_W-1];
    if (contact) begin
      np[1] = $signed(s5_mid.side.floor_h);
      nv[1] = '0;
    end
    s6_next.new_vel_x      = nv[0];
    s6_next.new_vel_y      = nv[1];
    s6_next.new_vel_z      = nv[2];
    s6_next.new_pos_x      = np[0];
    s6_next.new_pos_y      = np[1];
    s6_next.new_pos_z      = np[2];
    s6_next.was_updated    = s5_mid.side.upd;
    s6_next.ground_contact = contact;
  end

  always_ff @(posedge clk) begin
    if (s6_adv) result_data <= s6_next;
  end

  assign result_valid = s6_vld;

endmodule

@@ rtl/kinematic_euler_step_ground_clamp_unit.sv @@
// Kinematic body step with linear damping and floor clamp, Q16.16.
// Each accepted body beat passes the stage registers s1 to s6 in order.
// Throughput: one body per cycle unless result_ready stalls; six register
// stages, multiplies on stages 1, 3 and 5, the last stage the output register.
// Reset (rst, synchronous): empties the pipeline, loads gravity (0, -642908, 0)
// and time step 1092. Depends on kesgc_pkg and the kesgc_* modules.
module kinematic_euler_step_ground_clamp_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kesgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kesgc_pkg::WORD_W-1:0]    cfg_data,
  input  logic                            body_valid,
  output logic                            body_ready,
  input  kesgc_pkg::body_t                body_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output kesgc_pkg::result_t              result_data
);
  import kesgc_pkg::*;

  cfg_t cfg;
  logic mid_valid;
  logic mid_ready;
  mid_t mid_data;

  // configuration registers
  kesgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // velocity integration and damping
  kesgc_vel_pipe u_vel (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .body_valid (body_valid),
    .body_ready (body_ready),
    .body_data  (body_data),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_data   (mid_data)
  );

  // position update and floor clamp
  kesgc_pos_pipe u_pos (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .mid_valid    (mid_valid),
    .mid_ready    (mid_ready),
    .mid_data     (mid_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule
